// ----- rtl/core/spmv_pkg.sv -----
`default_nettype none

package spmv_pkg;

    // Length of the x vector and the width of its address.
    localparam int VECTOR_LENGTH = 1024;
    localparam int X_AW          = $clog2(VECTOR_LENGTH);

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);

    // Command codes of an input word.
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_ENTRY   = 2'd1;
    localparam logic [1:0] CMD_ROW_END = 2'd2;

    // Fill-mode codes; the unused codes behave as whole.
    localparam logic [2:0] FILL_WHOLE        = 3'd0;
    localparam logic [2:0] FILL_LOWER        = 3'd1;
    localparam logic [2:0] FILL_UPPER        = 3'd2;
    localparam logic [2:0] FILL_STRICT_LOWER = 3'd3;
    localparam logic [2:0] FILL_STRICT_UPPER = 3'd4;

    // Configuration register indexes.
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_ALPHA     = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_BETA      = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_FILL_MODE = 2'd2;

    // Alpha resets to 1.0 in Q16.16.
    localparam logic [31:0] ALPHA_RESET = 32'h0001_0000;

    // Kind of work handed from the front part to the back part.
    typedef enum logic {
        OP_MAC,
        OP_ROW_END
    } t_op;

    // Input word.
    typedef struct packed {
        logic [1:0]          cmd;
        logic [9:0]          row;
        logic [9:0]          col;
        logic signed [31:0]  value;
        logic signed [31:0]  y_in;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [9:0]          row_out;
        logic signed [31:0]  y_out;
        logic                saturated;
    } t_out_word;

    // Work word in the queue: opa is the entry value or y_in, opb is x[col].
    typedef struct packed {
        t_op                 op;
        logic [9:0]          row;
        logic signed [31:0]  opa;
        logic signed [31:0]  opb;
    } t_work_word;

endpackage

`default_nettype wire

// ----- rtl/core/spmv_front.sv -----
`default_nettype none

module spmv_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  spmv_pkg::t_in_word     i_in_data,
    input  wire  [2:0]             i_fill_mode,
    input  wire                    i_q_full,
    output logic                   o_push,
    output spmv_pkg::t_work_word   o_push_data
);
    import spmv_pkg::*;

    logic              accept;
    logic [X_AW-1:0]   x_idx;
    logic              in_range;
    logic              col_pass;
    logic              keep;

    logic              r_valid;
    t_op               r_op;
    logic [9:0]        r_row;
    logic [31:0]       r_opa;
    logic [31:0]       r_x_rd;
    logic [31:0]       r_x_mem [VECTOR_LENGTH];

    // The front stage holds one word; it stalls only while that word cannot enter the queue.
    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;

    assign x_idx    = X_AW'(i_in_data.col);
    assign in_range = (32'(i_in_data.col) < 32'(VECTOR_LENGTH));

    // Column mask against the row index.
    always_comb begin
        unique case (i_fill_mode)
            FILL_WHOLE:        col_pass = 1'b1;
            FILL_LOWER:        col_pass = (i_in_data.col <= i_in_data.row);
            FILL_UPPER:        col_pass = (i_in_data.col >= i_in_data.row);
            FILL_STRICT_LOWER: col_pass = (i_in_data.col <  i_in_data.row);
            FILL_STRICT_UPPER: col_pass = (i_in_data.col >  i_in_data.row);
            default:           col_pass = 1'b1;
        endcase
    end

    // Only counted entries and row ends go on to the back part.
    assign keep = ((i_in_data.cmd == CMD_ENTRY) && in_range && col_pass) ||
                  (i_in_data.cmd == CMD_ROW_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= keep;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= (i_in_data.cmd == CMD_ROW_END) ? OP_ROW_END : OP_MAC;
            r_row <= i_in_data.row;
            r_opa <= (i_in_data.cmd == CMD_ROW_END) ? i_in_data.y_in : i_in_data.value;
        end
    end

    // Vector store: loads write, entries read with a registered read.
    always_ff @(posedge i_clk) begin
        if (accept && (i_in_data.cmd == CMD_LOAD) && in_range) begin
            r_x_mem[x_idx] <= i_in_data.value;
        end
        if (accept && (i_in_data.cmd == CMD_ENTRY)) begin
            r_x_rd <= r_x_mem[x_idx];
        end
    end

    assign o_push_data.op  = r_op;
    assign o_push_data.row = r_row;
    assign o_push_data.opa = r_opa;
    assign o_push_data.opb = r_x_rd;

endmodule

`default_nettype wire

// ----- rtl/core/spmv_queue.sv -----
`default_nettype none

module spmv_queue (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  spmv_pkg::t_work_word   i_push_data,
    output logic                   o_full,
    input  wire                    i_pop,
    output spmv_pkg::t_work_word   o_pop_data,
    output logic                   o_empty
);
    import spmv_pkg::*;

    t_work_word       r_mem [QUEUE_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [Q_AW:0]    r_count;

    assign o_full     = (r_count == (Q_AW+1)'(QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    // Pointers wrap on their own since the depth is a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_AW+1)'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ----- rtl/core/spmv_back.sv -----
`default_nettype none

module spmv_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire  [31:0]            i_alpha,
    input  wire  [31:0]            i_beta,
    input  wire                    i_q_empty,
    input  spmv_pkg::t_work_word   i_q_data,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output spmv_pkg::t_out_word    o_out_data
);
    import spmv_pkg::*;

    logic                en;
    logic signed [31:0]  mul_a;
    logic signed [31:0]  mul_b;
    logic signed [31:0]  alpha_s;
    logic signed [32:0]  sum_lo_s;
    logic signed [31:0]  sum_hi_s;
    logic [63:0]         sum_next;
    logic                sum_ovf;
    logic [95:0]         rnd;
    logic                fits;

    // Stage 1: product.
    logic                r1_valid;
    t_op                 r1_op;
    logic [9:0]          r1_row;
    logic signed [63:0]  r1_prod;

    // Row accumulator.
    logic [63:0]         r_row_sum;
    logic                r_sum_ovf;

    // Stage 2: captured row sum of an ending row.
    logic                r2_valid;
    logic [9:0]          r2_row;
    logic [63:0]         r2_sum;
    logic                r2_ovf;
    logic signed [63:0]  r2_by;

    // Stage 3: partial products of alpha times the row sum.
    logic                r3_valid;
    logic [9:0]          r3_row;
    logic signed [64:0]  r3_plo;
    logic signed [63:0]  r3_phi;
    logic                r3_ovf;
    logic signed [63:0]  r3_by;

    // Stage 4: exact total in Q48.48.
    logic                r4_valid;
    logic [9:0]          r4_row;
    logic signed [95:0]  r4_tot;
    logic                r4_ovf;

    // Output register.
    logic                r_out_valid;
    t_out_word           r_out;

    // The whole pipeline moves unless a result waits on a stalled receiver.
    assign en    = !(r_out_valid && i_out_stall);
    assign o_pop = en && !i_q_empty;

    // One shared multiplier: value*x for entries, beta*y_in for row ends.
    assign mul_a = i_q_data.opa;
    assign mul_b = (i_q_data.op == OP_ROW_END) ? i_beta : i_q_data.opb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op   <= i_q_data.op;
            r1_row  <= i_q_data.row;
            r1_prod <= mul_a * mul_b;
        end
    end

    // Saturating accumulate of the product into the row sum.
    assign sum_next = r_row_sum + r1_prod;
    assign sum_ovf  = (r_row_sum[63] == r1_prod[63]) && (sum_next[63] != r1_prod[63]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_sum <= '0;
            r_sum_ovf <= 1'b0;
            r2_valid  <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid && (r1_op == OP_ROW_END);
            if (r1_valid) begin
                unique case (r1_op)
                    OP_MAC: begin
                        if (sum_ovf) begin
                            r_row_sum <= r1_prod[63] ? 64'h8000_0000_0000_0000
                                                     : 64'h7FFF_FFFF_FFFF_FFFF;
                            r_sum_ovf <= 1'b1;
                        end else begin
                            r_row_sum <= sum_next;
                        end
                    end
                    OP_ROW_END: begin
                        r_row_sum <= '0;
                        r_sum_ovf <= 1'b0;
                    end
                    default: begin
                        r_row_sum <= r_row_sum;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_row <= r1_row;
            r2_sum <= r_row_sum;
            r2_ovf <= r_sum_ovf;
            r2_by  <= r1_prod;
        end
    end

    // Alpha times the 64-bit sum as two 32-bit halves.
    assign alpha_s  = i_alpha;
    assign sum_lo_s = {1'b0, r2_sum[31:0]};
    assign sum_hi_s = r2_sum[63:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_row <= r2_row;
            r3_plo <= alpha_s * sum_lo_s;
            r3_phi <= alpha_s * sum_hi_s;
            r3_ovf <= r2_ovf;
            r3_by  <= r2_by;
            r4_row <= r3_row;
            r4_tot <= (96'(r3_phi) <<< 32) + 96'(r3_plo) + (96'(r3_by) <<< 16);
            r4_ovf <= r3_ovf;
        end
    end

    // Round half up to Q16.16 and saturate to 32 bits.
    assign rnd  = r4_tot + 96'h8000_0000;
    assign fits = (rnd[95:63] == '0) || (rnd[95:63] == '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r4_valid) begin
            r_out.row_out   <= r4_row;
            r_out.y_out     <= fits ? rnd[63:32]
                                    : (rnd[95] ? 32'h8000_0000 : 32'h7FFF_FFFF);
            r_out.saturated <= r4_ovf || !fits;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r1_valid && (r1_op == OP_ROW_END)) |=> ((r_row_sum == '0) && !r_sum_ovf))
        else $error("row sum not cleared after row end");

    a_ovf_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r4_valid && r4_ovf) |=> (r_out_valid && r_out.saturated))
        else $error("accumulator overflow not reported");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result word changed");

endmodule

`default_nettype wire

// ----- rtl/core/csr_sparse_matrix_vector_multiply_unit.sv -----
// Sparse matrix-vector multiply, y = alpha*A*x + beta*y, rows in compressed-row order.
// Input channel (i_in_valid / o_in_stall / i_in_data): load words fill the x vector,
// entry words add value*x[col] into the running row sum when the column passes the
// fill mask, and a row-end word carries the old y and yields one result word.
// Output channel (o_out_valid / i_out_stall / o_out_data) carries row, y and a
// saturation flag. Configuration (i_cfg_valid / o_cfg_ready) writes alpha, beta and
// fill mode; it is always ready. The user must write it only while the block is idle;
// the block does not enforce this. Throughput is one input word per cycle unless the
// queue or receiver stalls, set by the shared product multiplier in the back pipeline
// and the one-read-per-cycle x memory in the front stage. A row-end word passes the
// front stage, queue, product, accumulate, partial products, total and output register.
// Reset sets alpha to 1.0, beta to 0, fill mode to whole and clears the row sum;
// the x vector holds nothing defined until loaded and is not swept.
// When the receiver stalls, the back pipeline holds; the four-word queue then fills
// and o_in_stall rises until the result is taken.
`default_nettype none

module csr_sparse_matrix_vector_multiply_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  spmv_pkg::t_in_word                  i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output spmv_pkg::t_out_word                 o_out_data,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [spmv_pkg::CFG_IW-1:0]         i_cfg_index,
    input  wire  [31:0]                         i_cfg_data
);
    import spmv_pkg::*;

    logic [31:0]  r_alpha;
    logic [31:0]  r_beta;
    logic [2:0]   r_fill_mode;

    logic         push;
    t_work_word   push_data;
    logic         q_full;
    logic         pop;
    t_work_word   pop_data;
    logic         q_empty;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= ALPHA_RESET;
            r_beta      <= '0;
            r_fill_mode <= FILL_WHOLE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ALPHA:     r_alpha     <= i_cfg_data;
                CFG_BETA:      r_beta      <= i_cfg_data;
                CFG_FILL_MODE: r_fill_mode <= i_cfg_data[2:0];
                default:       r_alpha     <= r_alpha;
            endcase
        end
    end

    spmv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_fill_mode (r_fill_mode),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    spmv_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (q_empty)
    );

    spmv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_alpha     (r_alpha),
        .i_beta      (r_beta),
        .i_q_empty   (q_empty),
        .i_q_data    (pop_data),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
